// ----- rtl/ftmd_pkg.sv -----
package ftmd_pkg;

  localparam int unsigned D_STEP = 960;
  localparam int unsigned D_MAX  = 3840;
  localparam int unsigned A_STEP = 480;
  localparam int unsigned A_LIM  = 960;

  typedef logic [16:0] mu_t;
  typedef logic [2:0]  seg_t;
  typedef logic [2:0]  lvl_t;

  // Rule tables, index = angle_seg * 5 + distance_seg; entries are level codes 0..6.
  function automatic lvl_t left_rule(input logic [4:0] idx);
    lvl_t r;
    case (idx)
      5'd0: r = 3'd0;  5'd1: r = 3'd0;  5'd2: r = 3'd1;  5'd3: r = 3'd4;  5'd4: r = 3'd5;
      5'd5: r = 3'd0;  5'd6: r = 3'd1;  5'd7: r = 3'd2;  5'd8: r = 3'd4;  5'd9: r = 3'd5;
      5'd10: r = 3'd1; 5'd11: r = 3'd2; 5'd12: r = 3'd3; 5'd13: r = 3'd4; 5'd14: r = 3'd5;
      5'd15: r = 3'd1; 5'd16: r = 3'd2; 5'd17: r = 3'd4; 5'd18: r = 3'd5; 5'd19: r = 3'd6;
      5'd20: r = 3'd1; 5'd21: r = 3'd2; 5'd22: r = 3'd5; 5'd23: r = 3'd6; 5'd24: r = 3'd6;
      default: r = 3'd3;
    endcase
    return r;
  endfunction

  function automatic lvl_t right_rule(input logic [4:0] idx);
    lvl_t r;
    case (idx)
      5'd0: r = 3'd1;  5'd1: r = 3'd2;  5'd2: r = 3'd5;  5'd3: r = 3'd6;  5'd4: r = 3'd6;
      5'd5: r = 3'd1;  5'd6: r = 3'd2;  5'd7: r = 3'd4;  5'd8: r = 3'd5;  5'd9: r = 3'd6;
      5'd10: r = 3'd1; 5'd11: r = 3'd2; 5'd12: r = 3'd3; 5'd13: r = 3'd4; 5'd14: r = 3'd5;
      5'd15: r = 3'd0; 5'd16: r = 3'd1; 5'd17: r = 3'd2; 5'd18: r = 3'd4; 5'd19: r = 3'd5;
      5'd20: r = 3'd0; 5'd21: r = 3'd0; 5'd22: r = 3'd1; 5'd23: r = 3'd4; 5'd24: r = 3'd5;
      default: r = 3'd3;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/fuzzy_two_motor_drive.sv -----
`default_nettype none
// The valid bit runs through v1 and mu_valid in the fuzzifier, then v3, v4,
// v5 and done; the result is taken while done is high.
// Throughput: one transaction per cycle; busy is held low, so start may be
// high on every cycle. Results cannot be stalled and appear for one cycle.
// Reset (rst, synchronous, active high) clears the valid pipeline; no
// transaction in flight survives it. The block keeps no state between items.
module fuzzy_two_motor_drive
  import ftmd_pkg::*;
#(
  parameter int OUT_FRAC_BITS = 14
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [11:0] distance,
  input  wire logic [11:0] angle,
  output logic             done,
  output logic [15:0]      left_drive,
  output logic [15:0]      right_drive
);

  // Level magnitudes scaled by 2^OUT_FRAC_BITS, rounded half up.
  localparam longint L1 = ((64'd1000 << OUT_FRAC_BITS) + 500) / 1000;
  localparam longint L2 = ((64'd666  << OUT_FRAC_BITS) + 500) / 1000;
  localparam longint L3 = ((64'd333  << OUT_FRAC_BITS) + 500) / 1000;
  localparam int LW = OUT_FRAC_BITS + 2;   // signed level width

  assign busy = 1'b0;

  logic  mv;
  seg_t  ds, as_;
  mu_t   dh, ah;

  ftmd_fuzzify u_fuzz (
    .clk(clk), .rst(rst), .in_valid(start),
    .distance(distance), .angle(angle),
    .mu_valid(mv), .d_seg(ds), .d_hi(dh), .a_seg(as_), .a_hi(ah)
  );

  function automatic logic signed [LW-1:0] lvl(input lvl_t k);
    logic signed [LW-1:0] r;
    case (k)
      3'd0: r = -LW'(L1);
      3'd1: r = -LW'(L2);
      3'd2: r = -LW'(L3);
      3'd4: r = LW'(L3);
      3'd5: r = LW'(L2);
      3'd6: r = LW'(L1);
      default: r = '0;
    endcase
    return r;
  endfunction

  // Stage 3: the four nonzero rule weights (at most) and their rule levels.
  // Corners: (angle lo/hi) x (distance lo/hi).
  mu_t dl, al;
  always_comb begin
    dl = 17'd65536 - dh;
    al = 17'd65536 - ah;
  end

  logic        v3;
  logic [33:0] w3 [4];
  logic [4:0]  idx [4];
  always_comb begin
    idx[0] = 5'(as_ * 5 + ds);
    idx[1] = 5'(as_ * 5 + ds + 1);
    idx[2] = 5'((as_ + 1) * 5 + ds);
    idx[3] = 5'((as_ + 1) * 5 + ds + 1);
  end

  lvl_t lk3 [4];
  lvl_t rk3 [4];
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else     v3 <= mv;
    w3[0] <= al * dl;
    w3[1] <= al * dh;
    w3[2] <= ah * dl;
    w3[3] <= ah * dh;
    for (int i = 0; i < 4; i++) begin
      lk3[i] <= left_rule(idx[i]);
      rk3[i] <= right_rule(idx[i]);
    end
  end

  // Stage 4: weight times level, one product per corner and side.
  localparam int PW = 34 + LW;
  logic              v4;
  logic signed [PW-1:0] lp4 [4];
  logic signed [PW-1:0] rp4 [4];
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else     v4 <= v3;
    for (int i = 0; i < 4; i++) begin
      lp4[i] <= signed'({1'b0, w3[i]}) * lvl(lk3[i]);
      rp4[i] <= signed'({1'b0, w3[i]}) * lvl(rk3[i]);
    end
  end

  // Stage 5: sum and round half up at 2^32.
  localparam int SW = PW + 2;
  logic              v5;
  logic signed [SW-1:0] ls5, rs5;
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else     v5 <= v4;
    ls5 <= SW'(lp4[0]) + SW'(lp4[1]) + SW'(lp4[2]) + SW'(lp4[3]) + SW'(64'sd2147483648);
    rs5 <= SW'(rp4[0]) + SW'(rp4[1]) + SW'(rp4[2]) + SW'(rp4[3]) + SW'(64'sd2147483648);
  end

  function automatic logic [15:0] sat(input logic signed [SW-1:0] s);
    logic signed [SW-33:0] q;
    q = s[SW-1:32];
    if (q > (SW-32)'(32767))       return 16'h7fff;
    else if (q < -(SW-32)'(32768)) return 16'h8000;
    else                           return q[15:0];
  endfunction

  // Stage 6: saturate and register the result.
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= v5;
    left_drive  <= sat(ls5);
    right_drive <= sat(rs5);
  end

endmodule
`default_nettype wire

// ----- rtl/ftmd_fuzzify.sv -----
`default_nettype none
// Two-stage fuzzifier: clamp and segment, then reciprocal scaling of the offset.
module ftmd_fuzzify
  import ftmd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic [11:0] distance,
  input  wire logic [11:0] angle,
  output logic             mu_valid,
  output seg_t             d_seg,
  output mu_t              d_hi,
  output seg_t             a_seg,
  output mu_t              a_hi
);

  logic        v1;
  seg_t        dseg1, aseg1;
  logic [9:0]  doff1;
  logic [8:0]  aoff1;
  logic        dtop1, atop1;

  logic [11:0] dcl;
  logic [10:0] apos;
  logic signed [12:0] asx;

  always_comb begin
    dcl = (distance > 12'(D_MAX)) ? 12'(D_MAX) : distance;
    asx = 13'(signed'(angle));
    if (asx < -13'sd960)     apos = 11'd0;
    else if (asx > 13'sd960) apos = 11'(2 * A_LIM);
    else                     apos = 11'(asx + 13'sd960);
  end

  // Segment by compare ladder; keep the offset.
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= in_valid;
    dtop1 <= (dcl >= 12'(D_MAX));
    atop1 <= (apos >= 11'(2 * A_LIM));
    if (dcl >= 12'd2880)      begin dseg1 <= 3'd3; doff1 <= 10'(dcl - 12'd2880); end
    else if (dcl >= 12'd1920) begin dseg1 <= 3'd2; doff1 <= 10'(dcl - 12'd1920); end
    else if (dcl >= 12'd960)  begin dseg1 <= 3'd1; doff1 <= 10'(dcl - 12'd960);  end
    else                      begin dseg1 <= 3'd0; doff1 <= 10'(dcl); end
    if (apos >= 11'd1440)      begin aseg1 <= 3'd3; aoff1 <= 9'(apos - 11'd1440); end
    else if (apos >= 11'd960)  begin aseg1 <= 3'd2; aoff1 <= 9'(apos - 11'd960);  end
    else if (apos >= 11'd480)  begin aseg1 <= 3'd1; aoff1 <= 9'(apos - 11'd480);  end
    else                       begin aseg1 <= 3'd0; aoff1 <= 9'(apos); end
  end

  // round(off*65536/W): 65536/960 = 1024/15, 65536/480 = 2048/15.
  // q = floor((off*1024*2 + 15)/30) for distance; exact via reciprocal of 30.
  logic [20:0] dnum;
  logic [20:0] anum;
  logic [47:0] dprod, aprod;
  logic [16:0] dq, aq;
  always_comb begin
    dnum  = 21'({doff1, 11'd0}) + 21'd15;  // off*2048 + 15, then /30
    anum  = 21'({aoff1, 12'd0}) + 21'd15;  // off*4096 + 15, then /30
    dprod = 48'(dnum) * 48'd71582789;      // ceil(2^31/30)
    aprod = 48'(anum) * 48'd71582789;
    dq    = 17'(dprod >> 31);
    aq    = 17'(aprod >> 31);
  end

  always_ff @(posedge clk) begin
    if (rst) mu_valid <= 1'b0;
    else     mu_valid <= v1;
    d_seg <= dtop1 ? 3'd3 : dseg1;
    d_hi  <= dtop1 ? 17'd65536 : dq;
    a_seg <= atop1 ? 3'd3 : aseg1;
    a_hi  <= atop1 ? 17'd65536 : aq;
  end

endmodule
`default_nettype wire

// ----- rtl/ftmd_checker.sv -----
`default_nettype none
module ftmd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic [15:0] left_drive,
  input wire logic [15:0] right_drive
);

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##6 done) else $error("transaction lost");
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 6)) else $error("spurious done");
  a_never_busy: assert property (@(posedge clk) disable iff (rst)
    !busy) else $error("busy raised");
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> ($signed(left_drive) >= -16'sd16384 && $signed(left_drive) <= 16'sd16384
           && $signed(right_drive) >= -16'sd16384 && $signed(right_drive) <= 16'sd16384))
    else $error("drive out of range");

endmodule

bind fuzzy_two_motor_drive ftmd_checker u_ftmd_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .left_drive(left_drive), .right_drive(right_drive)
);
`default_nettype wire

// ----- tb/sv/fuzzy_two_motor_drive_checker.sv -----
`timescale 1ns / 1ps
module fuzzy_two_motor_drive_checker #(
  parameter int OUT_FRAC_BITS = 14
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [11:0] distance,
  input  wire logic [11:0] angle,
  input  wire logic        done,
  input  wire logic [15:0] left_drive,
  input  wire logic [15:0] right_drive,
  output int               fail_count,
  output int               pending
);
  import ftmd_pkg::*;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] right;
  } drive_pair_t;

  drive_pair_t drive_q[$];

  assign pending = drive_q.size();

  function automatic void fuzzify(input int unsigned pos, input int unsigned step,
                                  output longint unsigned mu[5]);
    int unsigned seg, off;
    longint unsigned hi;
    for (int k = 0; k < 5; k++) mu[k] = 0;
    if (pos >= 4 * step) begin
      mu[4] = 65536;
    end else begin
      seg = pos / step;
      off = pos % step;
      hi = (longint'(off) * 65536 + step / 2) / step;
      mu[seg] = 65536 - hi;
      mu[seg + 1] = hi;
    end
  endfunction

  function automatic longint level_of(input lvl_t code);
    longint m;
    int unsigned mag;
    case (code)
      3'd0, 3'd6: mag = 1000;
      3'd1, 3'd5: mag = 666;
      3'd2, 3'd4: mag = 333;
      default:    mag = 0;
    endcase
    m = ((longint'(mag) << OUT_FRAC_BITS) + 500) / 1000;
    return (code < 3'd3) ? -m : m;
  endfunction

  function automatic logic [15:0] blend(input longint unsigned mu_a[5],
                                        input longint unsigned mu_d[5], input bit right);
    longint acc, q;
    lvl_t code;
    acc = 0;
    for (int i = 0; i < 5; i++)
      for (int j = 0; j < 5; j++) begin
        code = right ? right_rule(5'(i * 5 + j)) : left_rule(5'(i * 5 + j));
        acc += longint'(mu_a[i] * mu_d[j]) * level_of(code);
      end
    // arithmetic shift gives floor, matching round-half-up toward +inf
    q = (acc + (longint'(1) << 31)) >>> 32;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic drive_pair_t predict_drives(input logic [11:0] d_raw,
                                                 input logic [11:0] a_raw);
    int unsigned d;
    int a;
    longint unsigned mu_d[5], mu_a[5];
    drive_pair_t p;
    d = d_raw;
    a = $signed(a_raw);
    if (d > D_MAX) d = D_MAX;
    if (a < -int'(A_LIM)) a = -int'(A_LIM);
    if (a > int'(A_LIM)) a = A_LIM;
    fuzzify(d, D_STEP, mu_d);
    fuzzify(a + A_LIM, A_STEP, mu_a);
    p.left = blend(mu_a, mu_d, 1'b0);
    p.right = blend(mu_a, mu_d, 1'b1);
    return p;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t: mismatch on %s: got %0d, want %0d", $realtime, what,
             $signed(got), $signed(want));
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    drive_pair_t want;
    if (!rst) begin
      if (done) begin
        if (drive_q.size() == 0) begin
          report_mismatch("unexpected result", left_drive, 16'd0);
        end else begin
          want = drive_q.pop_front();
          if (left_drive !== want.left) report_mismatch("left_drive", left_drive, want.left);
          if (right_drive !== want.right)
            report_mismatch("right_drive", right_drive, want.right);
        end
      end
      if (start && !busy) drive_q.push_back(predict_drives(distance, angle));
    end
  end
endmodule

// ----- tb/sv/fuzzy_two_motor_drive_tb.sv -----
`timescale 1ns / 1ps
module fuzzy_two_motor_drive_tb;
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [11:0] distance = '0;
  logic [11:0] angle = '0;
  wire         busy, done;
  wire  [15:0] left_drive, right_drive;
  int          fail_count, pending;
  int          cycle_count = 0;

  localparam int CYCLE_LIMIT = 200000;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  fuzzy_two_motor_drive dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .distance(distance),
    .angle(angle), .done(done), .left_drive(left_drive), .right_drive(right_drive)
  );

  fuzzy_two_motor_drive_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .distance(distance),
    .angle(angle), .done(done), .left_drive(left_drive), .right_drive(right_drive),
    .fail_count(fail_count), .pending(pending)
  );

  // Watchdog: bail out if the run hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one, often none at all.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Hold start high across back-to-back transactions; drop it only for a gap.
  task automatic send_sample(input logic [11:0] d, input logic [11:0] a, input int gap);
    start <= 1'b1;
    distance <= d;
    angle <= a;
    do @(posedge clk); while (busy);
    if (gap > 0) begin
      start <= 1'b0;
      distance <= 12'($urandom);
      angle <= 12'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [11:0] pick_distance();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 12'($urandom_range(0, 3840));
    if (r < 8) return 12'($urandom_range(0, 4) * 960 + $urandom_range(0, 2) - 1);
    return 12'($urandom);
  endfunction

  function automatic logic [11:0] pick_angle();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 12'($urandom_range(0, 1920) - 960);
    if (r < 8) return 12'($urandom_range(0, 4) * 480 - 960 + $urandom_range(0, 2) - 1);
    return 12'($urandom);
  endfunction

  initial begin
    logic [11:0] d_edge[8];
    logic [11:0] a_edge[8];
    d_edge = '{12'd0, 12'd1, 12'd960, 12'd1920, 12'd2880, 12'd3839, 12'd3840, 12'hfff};
    a_edge = '{12'h800, 12'hc40, 12'he20, 12'h000, 12'h1e0, 12'h3c0, 12'h3c1, 12'h7ff};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: breakpoints, clamps and saturation on both inputs.
    for (int i = 0; i < 8; i++) send_sample(d_edge[i], a_edge[i], 0);
    for (int i = 0; i < 8; i++) send_sample(d_edge[7 - i], a_edge[i], i % 2);
    for (int i = 0; i < 4; i++) send_sample(12'd480 + 12'(i), 12'hfff - 12'(i), 0);

    for (int n = 0; n < 2000; n++) send_sample(pick_distance(), pick_angle(), pick_gap());
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
